FILE: hdl/ssl_pkg.sv
package ssl_pkg;

  localparam int unsigned CoordW = 31;
  localparam int unsigned KeyW   = 2 * CoordW + 1;

  // sort key of one endpoint: x, then left before right, then ordered height
  typedef struct packed {
    logic [CoordW-1:0] x;
    logic              right;
    logic [CoordW-1:0] low;
  } endpoint_t;

  // request to the active height set
  typedef struct packed {
    logic              clear;
    logic              insert;
    logic              remove;
    logic [CoordW-1:0] height;
  } act_op_t;

endpackage

FILE: hdl/skyline_sweep_line.sv
// skyline sweep: buildings (left_x, right_x, height) are loaded one word at a
// time, each word's two endpoints written one after the other since both go
// through the single write port of the endpoint memory. the word flagged
// last_building starts the sweep: an insertion sort over the endpoint memory
// (one compare per cycle), then one pass over the sorted endpoints. a rising
// endpoint is written into the first free slot of the active height set; a
// falling one scans the set slot by slot to drop the height and refind the
// maximum. each change of the maximum gives a key point word; the final one
// carries last_point. overflow is set on every key point of a set from which
// buildings beyond MAX_BUILDINGS were dropped. a set whose sweep never
// changes the height gives no words at all. input stall stays high from the
// last building until the final key point has been taken into the output
// register.
module skyline_sweep_line #(
  parameter int unsigned MAX_BUILDINGS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [ssl_pkg::CoordW-1:0] left_x,
  input  logic [ssl_pkg::CoordW-1:0] right_x,
  input  logic [ssl_pkg::CoordW-1:0] height,
  input  logic                      last_building,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [ssl_pkg::CoordW-1:0] key_x,
  output logic [ssl_pkg::CoordW-1:0] key_height,
  output logic                      last_point,
  output logic                      overflow
);
  import ssl_pkg::*;

  localparam int unsigned Depth = 2 * MAX_BUILDINGS;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned CW    = $clog2(MAX_BUILDINGS + 1);
  localparam int unsigned NW    = CW + 1;
  localparam int unsigned IW    = (MAX_BUILDINGS > 1) ? $clog2(MAX_BUILDINGS) : 1;

  typedef enum logic [3:0] {
    T_LOAD, T_LOAD2, T_SORTGO, T_SORT, T_RD, T_EP, T_ACT, T_EMIT, T_FINISH
  } t_state_t;

  t_state_t          state;
  logic [CW-1:0]     count;
  logic [NW-1:0]     n;
  logic [NW-1:0]     idx;
  logic              overflow_seen;
  logic [CoordW-1:0] previous_max;
  logic [CoordW-1:0] hold_rx;
  logic [CoordW-1:0] hold_h;
  logic              hold_last;
  logic [CoordW-1:0] ep_x;
  logic              pend_valid;
  logic [CoordW-1:0] pend_x;
  logic [CoordW-1:0] pend_h;
  logic [CoordW-1:0] new_h;

  // endpoint memory and sorter
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [KeyW-1:0]   wr_data;
  logic [KeyW-1:0]   rd_data;
  logic              sort_start;
  logic              sort_done;
  endpoint_t         ep;

  // active height set
  act_op_t           op;
  logic              act_done;
  logic [CoordW-1:0] cur_max;

  logic              accept;
  logic              out_free;
  logic              room;
  logic              load_out;

  assign n        = {count, 1'b0};
  assign in_stall = (state != T_LOAD);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign room     = count < CW'(MAX_BUILDINGS);
  assign ep       = rd_data;

  // output register takes a key point word this cycle
  assign load_out = out_free && ((state == T_EMIT) || (state == T_FINISH && pend_valid));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = AW'(n);
    wr_data = {left_x, 1'b0, ~height};
    if (state == T_LOAD && accept && room) begin
      wr_en = 1'b1;
    end else if (state == T_LOAD2) begin
      wr_en   = 1'b1;
      wr_addr = AW'(n) + AW'(1);
      wr_data = {hold_rx, 1'b1, hold_h};
    end
  end

  assign sort_start = (state == T_SORTGO);

  // left endpoints carry the inverted height so that taller sorts first
  always_comb begin
    op        = '0;
    op.clear  = (state == T_SORTGO);
    op.height = ep.right ? ep.low : ~ep.low;
    if (state == T_EP) begin
      op.insert = !ep.right;
      op.remove = ep.right;
    end
  end

  ssl_store #(.DEPTH(Depth), .AW(AW), .NW(NW)) u_store (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (AW'(idx)),
    .rd_data   (rd_data),
    .sort_start(sort_start),
    .sort_n    (n),
    .sort_done (sort_done)
  );

  ssl_active #(.DEPTH(MAX_BUILDINGS), .IW(IW)) u_active (
    .clk    (clk),
    .rst    (rst),
    .op     (op),
    .done   (act_done),
    .cur_max(cur_max)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= T_LOAD;
      count         <= '0;
      idx           <= '0;
      overflow_seen <= 1'b0;
      previous_max  <= '0;
      pend_valid    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (load_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (state)
        T_LOAD: begin
          if (accept) begin
            hold_rx   <= right_x;
            hold_h    <= height;
            hold_last <= last_building;
            if (room) begin
              state <= T_LOAD2;
            end else begin
              overflow_seen <= 1'b1;
              if (last_building) state <= T_SORTGO;
            end
          end
        end
        T_LOAD2: begin
          count <= count + CW'(1);
          state <= hold_last ? T_SORTGO : T_LOAD;
        end
        T_SORTGO: begin
          previous_max <= '0;
          state        <= T_SORT;
        end
        T_SORT: begin
          if (sort_done) begin
            idx   <= '0;
            state <= (n == '0) ? T_FINISH : T_RD;
          end
        end
        T_RD: state <= T_EP;
        T_EP: begin
          ep_x  <= ep.x;
          state <= T_ACT;
        end
        T_ACT: begin
          if (act_done) begin
            if (cur_max != previous_max) begin
              previous_max <= cur_max;
              new_h        <= cur_max;
              if (pend_valid) begin
                state <= T_EMIT;
              end else begin
                pend_valid <= 1'b1;
                pend_x     <= ep_x;
                pend_h     <= cur_max;
                idx        <= idx + NW'(1);
                state      <= (idx + NW'(1) == n) ? T_FINISH : T_RD;
              end
            end else begin
              idx   <= idx + NW'(1);
              state <= (idx + NW'(1) == n) ? T_FINISH : T_RD;
            end
          end
        end
        T_EMIT: begin
          // previous key point is not the last one: send it, keep the new one
          if (out_free) begin
            key_x      <= pend_x;
            key_height <= pend_h;
            last_point <= 1'b0;
            overflow   <= overflow_seen;
            pend_x     <= ep_x;
            pend_h     <= new_h;
            idx        <= idx + NW'(1);
            state      <= (idx + NW'(1) == n) ? T_FINISH : T_RD;
          end
        end
        T_FINISH: begin
          if (!pend_valid || out_free) begin
            if (pend_valid) begin
              key_x      <= pend_x;
              key_height <= pend_h;
              last_point <= 1'b1;
              overflow   <= overflow_seen;
            end
            pend_valid    <= 1'b0;
            count         <= '0;
            overflow_seen <= 1'b0;
            previous_max  <= '0;
            state         <= T_LOAD;
          end
        end
        default: state <= T_LOAD;
      endcase
    end
  end

endmodule

FILE: hdl/ssl_store.sv
module ssl_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6,
  parameter int unsigned NW    = 7
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    wr_en,
  input  logic [AW-1:0]           wr_addr,
  input  logic [ssl_pkg::KeyW-1:0] wr_data,
  input  logic [AW-1:0]           rd_addr,
  output logic [ssl_pkg::KeyW-1:0] rd_data,
  input  logic                    sort_start,
  input  logic [NW-1:0]           sort_n,
  output logic                    sort_done
);
  import ssl_pkg::*;

  typedef enum logic [1:0] {SO_IDLE, SO_KEY, SO_CMP, SO_PLACE} so_state_t;

  logic [KeyW-1:0] mem [DEPTH];
  so_state_t       state;
  logic [NW-1:0]   i;
  logic [AW-1:0]   j;
  logic [KeyW-1:0] key;
  logic [NW-1:0]   n;

  logic            we;
  logic [AW-1:0]   wa;
  logic [KeyW-1:0] wd;
  logic [AW-1:0]   ra;
  logic            greater;

  assign greater = rd_data > key;

  always_comb begin
    we = wr_en;
    wa = wr_addr;
    wd = wr_data;
    ra = rd_addr;
    unique case (state)
      SO_IDLE: begin
        if (sort_start && sort_n > NW'(1)) ra = AW'(1);
      end
      SO_KEY: ra = AW'(i - NW'(1));
      SO_CMP: begin
        if (greater) begin
          we = 1'b1;
          wa = j;
          wd = rd_data;
          if (j != AW'(1)) ra = j - AW'(2);
        end
      end
      SO_PLACE: begin
        we = 1'b1;
        wa = j;
        wd = key;
        ra = AW'(i + NW'(1));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_data <= mem[ra];
  end

  // insertion sort, one compare per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= SO_IDLE;
      sort_done <= 1'b0;
    end else begin
      sort_done <= 1'b0;
      unique case (state)
        SO_IDLE: begin
          if (sort_start) begin
            n <= sort_n;
            if (sort_n > NW'(1)) begin
              i     <= NW'(1);
              state <= SO_KEY;
            end else begin
              sort_done <= 1'b1;
            end
          end
        end
        SO_KEY: begin
          key   <= rd_data;
          j     <= AW'(i);
          state <= SO_CMP;
        end
        SO_CMP: begin
          if (greater) begin
            j <= j - AW'(1);
            if (j == AW'(1)) state <= SO_PLACE;
          end else begin
            state <= SO_PLACE;
          end
        end
        SO_PLACE: begin
          if (i + NW'(1) == n) begin
            sort_done <= 1'b1;
            state     <= SO_IDLE;
          end else begin
            i     <= i + NW'(1);
            state <= SO_KEY;
          end
        end
        default: state <= SO_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/ssl_active.sv
module ssl_active #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned IW    = 5
) (
  input  logic                      clk,
  input  logic                      rst,
  input  ssl_pkg::act_op_t          op,
  output logic                      done,
  output logic [ssl_pkg::CoordW-1:0] cur_max
);
  import ssl_pkg::*;

  typedef enum logic {A_IDLE, A_SCAN} a_state_t;

  a_state_t          state;
  logic [CoordW-1:0] heights [DEPTH];
  logic [DEPTH-1:0]  valid;
  logic [IW-1:0]     idx;
  logic [CoordW-1:0] target;
  logic [CoordW-1:0] scan_max;
  logic              found;
  logic [IW-1:0]     free_idx;
  logic [CoordW-1:0] h_rd;
  logic              hit;
  logic [CoordW-1:0] max_upd;

  // first free slot
  always_comb begin
    free_idx = '0;
    for (int k = DEPTH - 1; k >= 0; k--) begin
      if (!valid[k]) free_idx = IW'(k);
    end
  end

  assign h_rd    = heights[idx];
  assign hit     = valid[idx] && !found && (h_rd == target);
  assign max_upd = (valid[idx] && !hit && h_rd > scan_max) ? h_rd : scan_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= A_IDLE;
      valid   <= '0;
      done    <= 1'b0;
      cur_max <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        A_IDLE: begin
          if (op.clear) begin
            valid   <= '0;
            cur_max <= '0;
          end else if (op.insert) begin
            valid[free_idx]   <= 1'b1;
            heights[free_idx] <= op.height;
            if (op.height > cur_max) cur_max <= op.height;
            done <= 1'b1;
          end else if (op.remove) begin
            target   <= op.height;
            idx      <= '0;
            found    <= 1'b0;
            scan_max <= '0;
            state    <= A_SCAN;
          end
        end
        A_SCAN: begin
          // drop the first matching slot, take the maximum of the rest
          if (hit) begin
            valid[idx] <= 1'b0;
            found      <= 1'b1;
          end
          scan_max <= max_upd;
          if (idx == IW'(DEPTH - 1)) begin
            cur_max <= max_upd;
            done    <= 1'b1;
            state   <= A_IDLE;
          end else begin
            idx <= idx + IW'(1);
          end
        end
        default: state <= A_IDLE;
      endcase
    end
  end

endmodule
